/* design/olre_pkg.sv */
// shared types and constants for the ordered list reorder engine
// no dependencies; imported by ordered_list_reorder_engine_core
package olre_pkg;

    localparam int LABEL_W         = 11;
    localparam int SUM_W           = 20;
    localparam int MAX_LABELS_DEF  = 1024;
    localparam logic [LABEL_W-1:0] BOX_COUNT_RESET = 11'd1024;

    // command codes
    localparam logic [2:0] OP_BEFORE = 3'd0;
    localparam logic [2:0] OP_AFTER  = 3'd1;
    localparam logic [2:0] OP_SWAP   = 3'd2;
    localparam logic [2:0] OP_REV    = 3'd3;
    localparam logic [2:0] OP_SUM    = 3'd4;
    localparam logic [2:0] OP_INIT   = 3'd5;

    typedef struct packed {
        logic [2:0]         opcode;
        logic [LABEL_W-1:0] first_label;
        logic [LABEL_W-1:0] second_label;
    } t_cmd;

    typedef struct packed {
        logic [SUM_W-1:0] odd_sum;
        logic             status;
    } t_result;

    typedef enum logic [3:0] {
        S_IDLE, S_RDX, S_RDY, S_NY, S_CHK, S_UNL, S_AT, S_LNK1, S_LNK2,
        S_SW1, S_SW2, S_INIT, S_SUM_H, S_SUM_A, S_SUM_B, S_DONE
    } t_state;

endpackage

/* design/ordered_list_reorder_engine_core.sv */
// a move that is already in place skips the unlink and relink steps; initialize writes every node in
// turn, and odd sum walks the list adding every other label (one sequencer, one access per table)
// throughput: one item at a time, busy stays high through the result strobe; the receiver
// cannot stall, the result is shown for exactly one cycle on o_done
// reset: synchronous active low, clears the sequencer, reverse flag and list length and sets
// box count to 1024; link tables hold nothing until the first initialize
module ordered_list_reorder_engine_core
    import olre_pkg::*;
#(
    parameter int MAX_LABELS = MAX_LABELS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  t_cmd               i_cmd,
    output logic               o_done,
    output t_result            o_result,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [LABEL_W-1:0] i_cfg_data
);

    localparam int NW    = $clog2(MAX_LABELS + 1);
    localparam int DEPTH = MAX_LABELS + 1;

    // four tables, one write and one registered read port each
    logic [NW-1:0] next_mem [DEPTH];
    logic [NW-1:0] prev_mem [DEPTH];
    logic [NW-1:0] nl_mem   [DEPTH];
    logic [NW-1:0] ln_mem   [DEPTH];

    logic          next_we, prev_we, nl_we, ln_we;
    logic [NW-1:0] next_wa, prev_wa, nl_wa, ln_wa;
    logic [NW-1:0] next_wd, prev_wd, nl_wd, ln_wd;
    logic [NW-1:0] next_ra, prev_ra, nl_ra, ln_ra;
    logic [NW-1:0] rd_next, rd_prev, rd_nl, rd_ln;

    t_state r_state, n_state;

    logic [2:0]         r_op;
    logic [LABEL_W-1:0] r_x, r_y;
    logic               r_before;
    logic [NW-1:0]      r_nx, r_ny, r_p, r_q, r_at, r_q2;
    logic [NW-1:0]      r_cnt, r_i, r_n, r_list_len;
    logic               r_rev;
    logic [SUM_W-1:0]   r_sum;
    logic               r_status;
    logic [LABEL_W-1:0] r_box_count;

    logic          accept;
    logic          bad;
    logic [NW-1:0] clamp_n;
    logic [NW-1:0] rd_link;
    logic [NW-1:0] at_sel;
    logic          satisfied;

    assign accept      = start && !busy;
    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_done      = (r_state == S_DONE);
    assign o_result    = '{odd_sum: r_sum, status: r_status};

    // operands must be distinct labels of the current list
    assign bad = (i_cmd.first_label == '0) || (i_cmd.second_label == '0)
              || (32'(i_cmd.first_label) > 32'(r_list_len))
              || (32'(i_cmd.second_label) > 32'(r_list_len))
              || (i_cmd.first_label == i_cmd.second_label);

    // initialize count clamped to 1..MAX_LABELS
    always_comb begin
        if (r_box_count == '0) begin
            clamp_n = NW'(1);
        end else if (32'(r_box_count) > 32'(MAX_LABELS)) begin
            clamp_n = NW'(MAX_LABELS);
        end else begin
            clamp_n = NW'(r_box_count);
        end
    end

    // walking direction follows the reverse flag
    assign rd_link   = r_rev ? rd_prev : rd_next;
    // anchor that the moved node goes after
    assign at_sel    = r_before ? rd_prev : r_ny;
    assign satisfied = r_before ? (rd_next == r_ny) : (rd_prev == r_ny);

    // tables
    always_ff @(posedge i_clk) begin
        if (next_we) begin
            next_mem[next_wa] <= next_wd;
        end
        rd_next <= next_mem[next_ra];
    end

    always_ff @(posedge i_clk) begin
        if (prev_we) begin
            prev_mem[prev_wa] <= prev_wd;
        end
        rd_prev <= prev_mem[prev_ra];
    end

    always_ff @(posedge i_clk) begin
        if (nl_we) begin
            nl_mem[nl_wa] <= nl_wd;
        end
        rd_nl <= nl_mem[nl_ra];
    end

    always_ff @(posedge i_clk) begin
        if (ln_we) begin
            ln_mem[ln_wa] <= ln_wd;
        end
        rd_ln <= ln_mem[ln_ra];
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_cmd.opcode) inside
                        OP_BEFORE, OP_AFTER, OP_SWAP: n_state = bad ? S_DONE : S_RDX;
                        OP_SUM:  n_state = S_SUM_H;
                        OP_INIT: n_state = S_INIT;
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_RDX:   n_state = S_RDY;
            S_RDY:   n_state = S_NY;
            S_NY:    n_state = (r_op == OP_SWAP) ? S_SW1 : S_CHK;
            S_CHK:   n_state = satisfied ? S_DONE : S_UNL;
            S_UNL:   n_state = S_AT;
            S_AT:    n_state = S_LNK1;
            S_LNK1:  n_state = S_LNK2;
            S_LNK2:  n_state = S_DONE;
            S_SW1:   n_state = S_SW2;
            S_SW2:   n_state = S_DONE;
            S_INIT:  n_state = (r_i == r_n) ? S_DONE : S_INIT;
            S_SUM_H: n_state = (r_cnt == '0) ? S_DONE : S_SUM_A;
            S_SUM_A: n_state = S_SUM_B;
            S_SUM_B: n_state = (r_cnt == NW'(1)) ? S_DONE : S_SUM_A;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // table access per step
    always_comb begin
        next_we = 1'b0; prev_we = 1'b0; nl_we = 1'b0; ln_we = 1'b0;
        next_wa = '0;   prev_wa = '0;   nl_wa = '0;   ln_wa = '0;
        next_wd = '0;   prev_wd = '0;   nl_wd = '0;   ln_wd = '0;
        next_ra = '0;   prev_ra = '0;   nl_ra = '0;   ln_ra = '0;
        unique case (r_state)
            S_RDX: ln_ra = NW'(r_x);
            S_RDY: ln_ra = NW'(r_y);
            S_NY: begin
                next_ra = r_nx;
                prev_ra = r_nx;
            end
            S_UNL: begin
                // unlink, and fetch the old predecessor of the reference node
                next_we = 1'b1; next_wa = r_p; next_wd = r_q;
                prev_we = 1'b1; prev_wa = r_q; prev_wd = r_p;
                prev_ra = r_ny;
            end
            S_AT: next_ra = at_sel;
            S_LNK1: begin
                next_we = 1'b1; next_wa = r_nx; next_wd = rd_next;
                prev_we = 1'b1; prev_wa = r_nx; prev_wd = r_at;
            end
            S_LNK2: begin
                prev_we = 1'b1; prev_wa = r_q2; prev_wd = r_nx;
                next_we = 1'b1; next_wa = r_at; next_wd = r_nx;
            end
            S_SW1: begin
                nl_we = 1'b1; nl_wa = r_nx;     nl_wd = NW'(r_y);
                ln_we = 1'b1; ln_wa = NW'(r_x); ln_wd = r_ny;
            end
            S_SW2: begin
                nl_we = 1'b1; nl_wa = r_ny;     nl_wd = NW'(r_x);
                ln_we = 1'b1; ln_wa = NW'(r_y); ln_wd = r_nx;
            end
            S_INIT: begin
                next_we = 1'b1; next_wa = r_i;
                next_wd = (r_i == r_n) ? '0 : r_i + NW'(1);
                prev_we = 1'b1; prev_wa = r_i;
                prev_wd = (r_i == '0) ? r_n : r_i - NW'(1);
                nl_we   = 1'b1; nl_wa = r_i; nl_wd = r_i;
                ln_we   = 1'b1; ln_wa = r_i; ln_wd = r_i;
            end
            S_SUM_H: begin
                next_ra = '0;
                prev_ra = '0;
            end
            S_SUM_A: begin
                next_ra = rd_link;
                prev_ra = rd_link;
                nl_ra   = rd_link;
            end
            S_SUM_B: begin
                // skip the even position
                next_ra = rd_link;
                prev_ra = rd_link;
            end
            default: begin
                next_ra = '0;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rev       <= 1'b0;
            r_list_len  <= '0;
            r_box_count <= BOX_COUNT_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_box_count <= i_cfg_data;
            end
            if (accept && i_cmd.opcode == OP_REV) begin
                r_rev <= ~r_rev;
            end
            if (r_state == S_INIT && r_i == r_n) begin
                r_list_len <= r_n;
                r_rev      <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    r_op     <= i_cmd.opcode;
                    r_x      <= i_cmd.first_label;
                    r_y      <= i_cmd.second_label;
                    r_before <= (i_cmd.opcode[0] ^ r_rev) == 1'b0;
                    r_sum    <= '0;
                    r_status <= (i_cmd.opcode > OP_INIT)
                             || (i_cmd.opcode <= OP_SWAP && bad);
                    r_n      <= clamp_n;
                    r_i      <= '0;
                    r_cnt    <= (r_list_len >> 1) + NW'(r_list_len[0]);
                end
            end
            S_RDY:  r_nx <= rd_ln;
            S_NY:   r_ny <= rd_ln;
            S_CHK: begin
                r_p <= rd_prev;
                r_q <= rd_next;
            end
            S_AT:   r_at <= at_sel;
            S_LNK1: r_q2 <= rd_next;
            S_INIT: r_i  <= r_i + NW'(1);
            S_SUM_B: begin
                r_sum <= r_sum + SUM_W'(rd_nl);
                r_cnt <= r_cnt - NW'(1);
            end
            default: begin
                r_op <= r_op;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("accepted item did not raise busy");

    a_done_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !busy)
        else $error("sequencer not idle after result");

    a_bad_no_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status) |-> (o_result.odd_sum == '0))
        else $error("ignored item carries a sum");

    a_init_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INIT && r_i == r_n) |=> (r_list_len != '0 && !r_rev))
        else $error("initialize left bad length or reverse flag");
`endif

endmodule

/* test/ordered_list_reorder_engine_core_tb.sv */
// self-checking testbench for ordered_list_reorder_engine_core
// depends on olre_pkg and the core; predicts each result from a local copy of the list
module ordered_list_reorder_engine_core_tb;
    import olre_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NMAX = MAX_LABELS_DEF;
    localparam int DEP = NMAX + 1;
    localparam int CYCLE_LIMIT = 3000000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    t_cmd               i_cmd = '0;
    logic               o_done;
    t_result            o_result;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [LABEL_W-1:0] i_cfg_data = '0;

    ordered_list_reorder_engine_core i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_cmd(i_cmd),
        .o_done(o_done), .o_result(o_result), .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // shadow copy of the list
    int unsigned nxt [DEP];
    int unsigned prv [DEP];
    int unsigned lab_of_node [DEP];
    int unsigned node_of_lab [DEP];
    bit          rev_shadow;
    int unsigned len_shadow;
    int unsigned count_shadow;

    t_result     pending_results [$];
    int          error_count;
    int          item_count;
    int          result_count;
    int          sum_count;
    longint      cycle_count;

    function automatic int unsigned clip(int unsigned v);
        return (v < DEP) ? v : 0;
    endfunction

    function automatic void shadow_unlink(int unsigned n);
        int unsigned p;
        int unsigned q;
        p = clip(prv[n]);
        q = clip(nxt[n]);
        nxt[p] = q;
        prv[q] = p;
    endfunction

    function automatic void shadow_link_after(int unsigned n, int unsigned at);
        int unsigned q;
        q = clip(nxt[at]);
        prv[n] = at;
        nxt[n] = q;
        prv[q] = n;
        nxt[at] = n;
    endfunction

    // applies one command to the shadow list and returns its result
    function automatic t_result apply_command(t_cmd c);
        t_result     r;
        logic [2:0]  op;
        int unsigned x;
        int unsigned y;
        int unsigned nx;
        int unsigned ny;
        int unsigned cur;
        int unsigned n;
        longint      acc;
        r = '0;
        op = c.opcode;
        x = c.first_label;
        y = c.second_label;
        if (op <= OP_SWAP) begin
            if (x < 1 || x > len_shadow || y < 1 || y > len_shadow || x == y) begin
                r.status = 1'b1;
            end else begin
                nx = clip(node_of_lab[x]);
                ny = clip(node_of_lab[y]);
                if (op == OP_SWAP) begin
                    lab_of_node[nx] = y;
                    lab_of_node[ny] = x;
                    node_of_lab[x] = ny;
                    node_of_lab[y] = nx;
                end else begin
                    // reversed view swaps the meaning of before and after
                    if (rev_shadow) op = (op == OP_BEFORE) ? OP_AFTER : OP_BEFORE;
                    if (op == OP_BEFORE) begin
                        if (nxt[nx] != ny) begin
                            shadow_unlink(nx);
                            shadow_link_after(nx, clip(prv[ny]));
                        end
                    end else if (prv[nx] != ny) begin
                        shadow_unlink(nx);
                        shadow_link_after(nx, ny);
                    end
                end
            end
        end else if (op == OP_REV) begin
            rev_shadow = ~rev_shadow;
        end else if (op == OP_SUM) begin
            acc = 0;
            cur = rev_shadow ? clip(prv[0]) : clip(nxt[0]);
            for (int i = 0; i < (len_shadow + 1) / 2; i++) begin
                acc += lab_of_node[cur];
                cur = rev_shadow ? clip(prv[clip(prv[cur])]) : clip(nxt[clip(nxt[cur])]);
            end
            r.odd_sum = acc[SUM_W-1:0];
        end else if (op == OP_INIT) begin
            n = count_shadow;
            if (n < 1) n = 1;
            if (n > NMAX) n = NMAX;
            for (int unsigned i = 0; i <= n; i++) begin
                nxt[i] = (i == n) ? 0 : i + 1;
                prv[i] = (i == 0) ? n : i - 1;
                lab_of_node[i] = i;
                node_of_lab[i] = i;
            end
            len_shadow = n;
            rev_shadow = 1'b0;
        end else begin
            r.status = 1'b1;
        end
        return r;
    endfunction

    // result checker: the receiver always takes the strobed result
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_done) begin
            result_count <= result_count + 1;
            if (pending_results.size() == 0) begin
                $error("result with no pending item: odd_sum %0d status %0d",
                       o_result.odd_sum, o_result.status);
                error_count <= error_count + 1;
            end else begin
                if (o_result.odd_sum !== pending_results[0].odd_sum) begin
                    $error("odd_sum expected %0d actual %0d",
                           pending_results[0].odd_sum, o_result.odd_sum);
                    error_count <= error_count + 1;
                end
                if (o_result.status !== pending_results[0].status) begin
                    $error("status expected %0d actual %0d",
                           pending_results[0].status, o_result.status);
                    error_count <= error_count + 1;
                end
                void'(pending_results.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    task automatic idle_gap();
        int g;
        g = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) g = 0;
        repeat (g) @(posedge i_clk);
    endtask

    // sends one item; the expected result is predicted at the accepting edge
    task automatic send_item(logic [2:0] op, int unsigned x, int unsigned y);
        t_cmd c;
        c.opcode = op;
        c.first_label = x[LABEL_W-1:0];
        c.second_label = y[LABEL_W-1:0];
        start <= 1'b1;
        i_cmd <= c;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_results.push_back(apply_command(c));
        item_count++;
        if (op == OP_SUM) sum_count++;
        start <= 1'b0;
        // the engine is busy for this edge anyway
        @(posedge i_clk);
    endtask

    task automatic drain_results();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // box count is only written with the engine idle
    task automatic write_box_count(int unsigned v);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v[LABEL_W-1:0];
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        count_shadow = v & 11'h7ff;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic int unsigned pick_label();
        int unsigned k;
        k = $urandom_range(0, 19);
        if (k == 0) return $urandom_range(0, 2047);
        if (k == 1) return len_shadow;
        return $urandom_range(1, (len_shadow > 0) ? len_shadow : 1);
    endfunction

    task automatic test_before_init();
        send_item(OP_SUM, 0, 0);
        send_item(OP_BEFORE, 1, 2);
        send_item(OP_SWAP, 1, 2);
        send_item(OP_REV, 2047, 2047);
        send_item(OP_SUM, 0, 0);
        send_item(OP_REV, 0, 0);
    endtask

    task automatic test_directed();
        write_box_count(1024);
        send_item(OP_INIT, 2047, 0);
        send_item(OP_SUM, 0, 0);
        send_item(OP_BEFORE, 1024, 1);
        send_item(OP_AFTER, 1, 1024);
        send_item(OP_BEFORE, 1, 2);
        send_item(OP_SWAP, 1, 1024);
        send_item(OP_BEFORE, 0, 5);
        send_item(OP_AFTER, 5, 1025);
        send_item(OP_SWAP, 7, 7);
        send_item(3'd6, 1, 2);
        send_item(3'd7, 2047, 2047);
        send_item(OP_REV, 0, 0);
        send_item(OP_BEFORE, 3, 9);
        send_item(OP_AFTER, 4, 9);
        send_item(OP_SUM, 0, 0);
        // count zero clamps to one label
        write_box_count(0);
        send_item(OP_INIT, 0, 0);
        send_item(OP_SUM, 0, 0);
        send_item(OP_BEFORE, 1, 1);
        // count above the maximum clamps
        write_box_count(2047);
        send_item(OP_INIT, 0, 0);
        send_item(OP_SUM, 0, 0);
    endtask

    task automatic test_random_phase(int unsigned cnt, int items);
        int unsigned k;
        write_box_count(cnt);
        send_item(OP_INIT, $urandom, $urandom);
        for (int i = 0; i < items; i++) begin
            idle_gap();
            k = $urandom_range(0, 99);
            if (k < 30) send_item(OP_BEFORE, pick_label(), pick_label());
            else if (k < 60) send_item(OP_AFTER, pick_label(), pick_label());
            else if (k < 78) send_item(OP_SWAP, pick_label(), pick_label());
            else if (k < 86) send_item(OP_REV, $urandom, $urandom);
            else if (k < 96) send_item(OP_SUM, $urandom, $urandom);
            else if (k < 98) send_item(3'($urandom_range(6, 7)), $urandom, $urandom);
            else send_item(OP_INIT, $urandom, $urandom);
            // hold-off until the engine has answered everything
            if (i == items / 2) drain_results();
        end
    endtask

    task automatic test_random();
        test_random_phase(2, 60);
        test_random_phase(9, 250);
        test_random_phase(37, 300);
        test_random_phase(200, 200);
        test_random_phase(1024, 60);
        test_random_phase(1, 40);
        test_random_phase($urandom_range(3, 64), 40);
    endtask

    initial begin
        error_count = 0;
        item_count = 0;
        result_count = 0;
        sum_count = 0;
        cycle_count = 0;
        rev_shadow = 1'b0;
        len_shadow = 0;
        count_shadow = BOX_COUNT_RESET;
        for (int i = 0; i < DEP; i++) begin
            nxt[i] = 0; prv[i] = 0; lab_of_node[i] = 0; node_of_lab[i] = 0;
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_before_init();
        test_directed();
        test_random();
        drain_results();
        repeat (2100) @(posedge i_clk);
        $display("sent %0d items (%0d odd-sum queries), checked %0d results",
                 item_count, sum_count, result_count);
        $display("list sizes from 1 to 1024 labels with moves, swaps and reversal");
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

/* filelist.f */
design/olre_pkg.sv
design/ordered_list_reorder_engine_core.sv
test/ordered_list_reorder_engine_core_tb.sv
